// ===== hw/rtl/mm_pkg.sv =====
// Shared types, field widths and codes for the matrix multiply block.
package mm_pkg;

   localparam int MAX_DIM_DEFAULT = 8;

   localparam int OP_W       = 2;
   localparam int IDX_W      = 3;
   localparam int ELEM_W     = 16;
   localparam int MUL_W      = 2 * ELEM_W;
   localparam int PROD_W     = 35;
   localparam int CNT_W      = 4;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 2;

   localparam logic [OP_W-1:0] OP_LOAD_A  = 2'd0;
   localparam logic [OP_W-1:0] OP_LOAD_B  = 2'd1;
   localparam logic [OP_W-1:0] OP_COMPUTE = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_A_ROW_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_A_COL_COUNT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_B_ROW_COUNT = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_B_COL_COUNT = 2'd3;

   localparam logic [CNT_W-1:0] COUNT_RESET = 4'd8;

   typedef struct packed {
      logic [CNT_W-1:0] a_row_count;
      logic [CNT_W-1:0] a_col_count;
      logic [CNT_W-1:0] b_row_count;
      logic [CNT_W-1:0] b_col_count;
   } mm_cfg_type;

   typedef struct packed {
      logic wr_a;
      logic wr_b;
      logic mac_valid;
      logic mac_first;
      logic mac_last;
      logic elem_last;
      logic emit_error;
   } mm_cmd_type;

   typedef struct packed {
      logic out_free;
      logic mac_done;
   } mm_stat_type;

endpackage

// ===== hw/rtl/mm_req_if.sv =====
// Request channel of the matrix multiply block: loads and compute requests.
interface mm_req_if;
   import mm_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [OP_W-1:0]          operation;
   logic [IDX_W-1:0]         row_index;
   logic [IDX_W-1:0]         col_index;
   logic signed [ELEM_W-1:0] element_value;

   modport source (output valid, operation, row_index, col_index, element_value,
                   input ready);
   modport sink   (input valid, operation, row_index, col_index, element_value,
                   output ready);
endinterface

// ===== hw/rtl/mm_rsp_if.sv =====
// Response channel of the matrix multiply block: product elements and errors.
interface mm_rsp_if;
   import mm_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [PROD_W-1:0] product_value;
   logic [IDX_W-1:0]         out_row;
   logic [IDX_W-1:0]         out_col;
   logic                     size_error;
   logic                     last_item;

   modport source (output valid, product_value, out_row, out_col, size_error, last_item,
                   input ready);
   modport sink   (input valid, product_value, out_row, out_col, size_error, last_item,
                   output ready);
endinterface

// ===== hw/rtl/matrix_multiply.sv =====
// Top level of the matrix multiply block: configuration registers, controller and datapath.
// A load beat is taken every cycle while no product is computed and no error beat waits.
// Compute requests run on the single multiply-accumulate unit, one element at a time;
// each element passes the read and product registers on its way to the output register.
// A stalled result holds the next element back, and load beats are refused during a run.
// Synchronous active-high reset clears the control state and sets every count to 8.
module matrix_multiply #(
   parameter int MAX_DIM = mm_pkg::MAX_DIM_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   mm_req_if.sink                          req_bus,
   mm_rsp_if.source                        rsp_bus,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [mm_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [mm_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [mm_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                            pready
);
   import mm_pkg::*;

   localparam int DIM_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

   mm_cfg_type       cfg;
   mm_cmd_type       cmd;
   mm_stat_type      stat;
   logic [DIM_W-1:0] step_i, step_j, step_k;

   mm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   mm_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .operation (req_bus.operation),
      .cfg       (cfg),
      .stat      (stat),
      .cmd       (cmd),
      .step_i    (step_i),
      .step_j    (step_j),
      .step_k    (step_k)
   );

   mm_dp #(.MAX_DIM(MAX_DIM)) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .step_i      (step_i),
      .step_j      (step_j),
      .step_k      (step_k),
      .ld_row      (req_bus.row_index),
      .ld_col      (req_bus.col_index),
      .ld_value    (req_bus.element_value),
      .out_valid   (rsp_bus.valid),
      .out_ready   (rsp_bus.ready),
      .out_product (rsp_bus.product_value),
      .out_row     (rsp_bus.out_row),
      .out_col     (rsp_bus.out_col),
      .out_error   (rsp_bus.size_error),
      .out_last    (rsp_bus.last_item)
   );

endmodule

// ===== hw/rtl/mm_csr.sv =====
// Configuration registers holding the matrix dimensions, written over the APB port.
module mm_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [mm_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [mm_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [mm_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                               pready,
   output mm_pkg::mm_cfg_type                 cfg
);
   import mm_pkg::*;

   logic [CNT_W-1:0]     a_row_count_ff, a_row_count_in;
   logic [CNT_W-1:0]     a_col_count_ff, a_col_count_in;
   logic [CNT_W-1:0]     b_row_count_ff, b_row_count_in;
   logic [CNT_W-1:0]     b_col_count_ff, b_col_count_in;
   logic [CSR_IDX_W-1:0] reg_index;
   logic [CNT_W-1:0]     read_value;
   logic                 write_en;

   assign reg_index = paddr[CSR_ADDR_W-1:CSR_ADDR_W-CSR_IDX_W];
   assign write_en  = psel && penable && pwrite;
   assign pready    = 1'b1;

   always_comb begin
      a_row_count_in = a_row_count_ff;
      a_col_count_in = a_col_count_ff;
      b_row_count_in = b_row_count_ff;
      b_col_count_in = b_col_count_ff;
      if (write_en) begin
         case (reg_index)
            REG_A_ROW_COUNT: a_row_count_in = pwdata[CNT_W-1:0];
            REG_A_COL_COUNT: a_col_count_in = pwdata[CNT_W-1:0];
            REG_B_ROW_COUNT: b_row_count_in = pwdata[CNT_W-1:0];
            REG_B_COL_COUNT: b_col_count_in = pwdata[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_A_ROW_COUNT: read_value = a_row_count_ff;
         REG_A_COL_COUNT: read_value = a_col_count_ff;
         REG_B_ROW_COUNT: read_value = b_row_count_ff;
         REG_B_COL_COUNT: read_value = b_col_count_ff;
         default:         read_value = '0;
      endcase
   end

   assign prdata = CSR_DATA_W'(read_value);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_row_count_ff <= COUNT_RESET;
         a_col_count_ff <= COUNT_RESET;
         b_row_count_ff <= COUNT_RESET;
         b_col_count_ff <= COUNT_RESET;
      end else begin
         a_row_count_ff <= a_row_count_in;
         a_col_count_ff <= a_col_count_in;
         b_row_count_ff <= b_row_count_in;
         b_col_count_ff <= b_col_count_in;
      end
   end

   assign cfg.a_row_count = a_row_count_ff;
   assign cfg.a_col_count = a_col_count_ff;
   assign cfg.b_row_count = b_row_count_ff;
   assign cfg.b_col_count = b_col_count_ff;

endmodule

// ===== hw/rtl/mm_ctrl.sv =====
// Controller state machine that sequences loads, the multiply-accumulate loop and errors.
module mm_ctrl #(
   parameter int MAX_DIM = mm_pkg::MAX_DIM_DEFAULT,
   localparam int DIM_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [mm_pkg::OP_W-1:0]     operation,
   input  mm_pkg::mm_cfg_type          cfg,
   input  mm_pkg::mm_stat_type         stat,
   output mm_pkg::mm_cmd_type          cmd,
   output logic [DIM_W-1:0]            step_i,
   output logic [DIM_W-1:0]            step_j,
   output logic [DIM_W-1:0]            step_k
);
   import mm_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_ISSUE = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_ERROR = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [DIM_W-1:0] i_ff, i_in;
   logic [DIM_W-1:0] j_ff, j_in;
   logic [DIM_W-1:0] k_ff, k_in;
   logic [DIM_W-1:0] m_last, n_last, inner_last, inner_b_last;
   logic             mismatch;
   logic             elem_last;

   // Saturates a count register to 1..MAX_DIM and returns the last index.
   function automatic logic [DIM_W-1:0] last_index(input logic [CNT_W-1:0] raw);
      logic [DIM_W-1:0] result;
      if (raw == '0) begin
         result = '0;
      end else if (int'(raw) > MAX_DIM) begin
         result = DIM_W'(MAX_DIM - 1);
      end else begin
         result = DIM_W'(raw - 1'b1);
      end
      return result;
   endfunction

   assign m_last       = last_index(cfg.a_row_count);
   assign inner_last   = last_index(cfg.a_col_count);
   assign inner_b_last = last_index(cfg.b_row_count);
   assign n_last       = last_index(cfg.b_col_count);
   assign mismatch     = inner_last != inner_b_last;
   assign elem_last    = (i_ff == m_last) && (j_ff == n_last);

   always_comb begin
      state_in  = state_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      k_in      = k_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (operation)
                  OP_LOAD_A: cmd.wr_a = 1'b1;
                  OP_LOAD_B: cmd.wr_b = 1'b1;
                  OP_COMPUTE: begin
                     if (mismatch) begin
                        state_in = ST_ERROR;
                     end else begin
                        i_in     = '0;
                        j_in     = '0;
                        k_in     = '0;
                        state_in = ST_ISSUE;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_ISSUE: begin
            // An element only starts once the output register will be free for its result.
            if (k_ff != '0 || stat.out_free) begin
               cmd.mac_valid = 1'b1;
               cmd.mac_first = k_ff == '0;
               cmd.mac_last  = k_ff == inner_last;
               cmd.elem_last = elem_last;
               if (k_ff == inner_last) begin
                  k_in     = '0;
                  state_in = ST_DRAIN;
               end else begin
                  k_in = DIM_W'(k_ff + 1'b1);
               end
            end
         end
         ST_DRAIN: begin
            if (stat.mac_done) begin
               if (elem_last) begin
                  state_in = ST_IDLE;
               end else begin
                  if (j_ff == n_last) begin
                     j_in = '0;
                     i_in = DIM_W'(i_ff + 1'b1);
                  end else begin
                     j_in = DIM_W'(j_ff + 1'b1);
                  end
                  state_in = ST_ISSUE;
               end
            end
         end
         ST_ERROR: begin
            if (stat.out_free) begin
               cmd.emit_error = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         i_ff     <= '0;
         j_ff     <= '0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         k_ff     <= k_in;
      end
   end

   assign step_i = i_ff;
   assign step_j = j_ff;
   assign step_k = k_ff;

endmodule

// ===== hw/rtl/mm_dp.sv =====
// Datapath with the two element stores, the multiply-accumulate pipeline and the output register.
module mm_dp #(
   parameter int MAX_DIM = mm_pkg::MAX_DIM_DEFAULT,
   localparam int DIM_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1
) (
   input  logic                                clock,
   input  logic                                reset,
   input  mm_pkg::mm_cmd_type                  cmd,
   output mm_pkg::mm_stat_type                 stat,
   input  logic [DIM_W-1:0]                    step_i,
   input  logic [DIM_W-1:0]                    step_j,
   input  logic [DIM_W-1:0]                    step_k,
   input  logic [mm_pkg::IDX_W-1:0]            ld_row,
   input  logic [mm_pkg::IDX_W-1:0]            ld_col,
   input  logic signed [mm_pkg::ELEM_W-1:0]    ld_value,
   output logic                                out_valid,
   input  logic                                out_ready,
   output logic signed [mm_pkg::PROD_W-1:0]    out_product,
   output logic [mm_pkg::IDX_W-1:0]            out_row,
   output logic [mm_pkg::IDX_W-1:0]            out_col,
   output logic                                out_error,
   output logic                                out_last
);
   import mm_pkg::*;

   localparam int DEPTH  = MAX_DIM * MAX_DIM;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic signed [ELEM_W-1:0] a_store_ff [DEPTH];
   logic signed [ELEM_W-1:0] b_store_ff [DEPTH];

   logic [ADDR_W-1:0]        ld_addr, rd_a_addr, rd_b_addr;
   logic                     ld_ok;

   logic signed [ELEM_W-1:0] a_rd_ff, b_rd_ff;
   logic                     v1_ff, v1_in;
   logic                     first1_ff, last1_ff, elast1_ff;
   logic [DIM_W-1:0]         row1_ff, col1_ff;

   logic signed [MUL_W-1:0]  prod_ff, prod_in;
   logic                     v2_ff, v2_in;
   logic                     first2_ff, last2_ff, elast2_ff;
   logic [DIM_W-1:0]         row2_ff, col2_ff;

   logic signed [PROD_W-1:0] acc_ff, acc_in;
   logic                     mac_done;

   logic                     out_valid_ff, out_valid_in;
   logic signed [PROD_W-1:0] out_product_ff;
   logic [IDX_W-1:0]         out_row_ff, out_col_ff;
   logic                     out_error_ff, out_last_ff;

   assign ld_ok     = (int'(ld_row) < MAX_DIM) && (int'(ld_col) < MAX_DIM);
   assign ld_addr   = ADDR_W'(int'(ld_row) * MAX_DIM + int'(ld_col));
   assign rd_a_addr = ADDR_W'(int'(step_i) * MAX_DIM + int'(step_k));
   assign rd_b_addr = ADDR_W'(int'(step_k) * MAX_DIM + int'(step_j));

   always_ff @(posedge clock) begin
      if (cmd.wr_a && ld_ok) begin
         a_store_ff[ld_addr] <= ld_value;
      end
      if (cmd.wr_b && ld_ok) begin
         b_store_ff[ld_addr] <= ld_value;
      end
      if (cmd.mac_valid) begin
         a_rd_ff <= a_store_ff[rd_a_addr];
         b_rd_ff <= b_store_ff[rd_b_addr];
      end
   end

   assign v1_in    = cmd.mac_valid;
   assign v2_in    = v1_ff;
   assign prod_in  = a_rd_ff * b_rd_ff;
   assign acc_in   = first2_ff ? PROD_W'(prod_ff) : acc_ff + PROD_W'(prod_ff);
   assign mac_done = v2_ff && last2_ff;

   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.emit_error || mac_done) begin
         out_valid_in = 1'b1;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mac_valid) begin
         first1_ff <= cmd.mac_first;
         last1_ff  <= cmd.mac_last;
         elast1_ff <= cmd.elem_last;
         row1_ff   <= step_i;
         col1_ff   <= step_j;
      end
      if (v1_ff) begin
         prod_ff   <= prod_in;
         first2_ff <= first1_ff;
         last2_ff  <= last1_ff;
         elast2_ff <= elast1_ff;
         row2_ff   <= row1_ff;
         col2_ff   <= col1_ff;
      end
      if (v2_ff) begin
         acc_ff <= acc_in;
      end
      if (cmd.emit_error) begin
         out_product_ff <= '0;
         out_row_ff     <= '0;
         out_col_ff     <= '0;
         out_error_ff   <= 1'b1;
         out_last_ff    <= 1'b1;
      end else if (mac_done) begin
         out_product_ff <= acc_in;
         out_row_ff     <= IDX_W'(row2_ff);
         out_col_ff     <= IDX_W'(col2_ff);
         out_error_ff   <= 1'b0;
         out_last_ff    <= elast2_ff;
      end
   end

   assign stat.out_free = !out_valid_ff || out_ready;
   assign stat.mac_done = mac_done;

   assign out_valid   = out_valid_ff;
   assign out_product = out_product_ff;
   assign out_row     = out_row_ff;
   assign out_col     = out_col_ff;
   assign out_error   = out_error_ff;
   assign out_last    = out_last_ff;

endmodule
